### sv/binary_image_bbox_centering_assert.svh
`ifndef BINARY_IMAGE_BBOX_CENTERING_ASSERT_SVH
`define BINARY_IMAGE_BBOX_CENTERING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BIBC_CHK_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bibc check failed");
`define BIBC_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bibc check failed");
`else
`define BIBC_CHK_IMM(lbl, ante, cons)
`define BIBC_CHK_NXT(lbl, ante, cons)
`endif
`endif

### sv/bibc_pkg.sv
package bibc_pkg;

  localparam int ROW_W    = 40;
  localparam int CHUNK_W  = 8;
  localparam int CHUNK_IW = 3;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_OFFS = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

### sv/bibc_row_ram.sv
module bibc_row_ram #(
  parameter int DEPTH = 40,
  parameter int WIDTH = 40,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/bibc_edge_scan.sv
`include "binary_image_bbox_centering_assert.svh"

module bibc_edge_scan #(
  parameter int SIZE  = 40,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SIZE-1:0]  vec,
  output logic             done,
  output logic [IDX_W-1:0] left,
  output logic [IDX_W-1:0] right
);
  import bibc_pkg::*;

  localparam int NCH  = (SIZE + CHUNK_W - 1) / CHUNK_W;
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NCH - 1);

  logic [NCH*CHUNK_W+SIZE-1:0] vext;
  logic [NCH*CHUNK_W-1:0]      vpad;
  logic [CHUNK_W-1:0]          chunk;
  logic [CHUNK_IW-1:0]         lo;
  logic [CHUNK_IW-1:0]         hi;
  logic                        busy_r;
  logic                        found_r;
  logic                        done_r;
  logic [CH_W-1:0]             cnt_r;
  logic [IDX_W-1:0]            left_r;
  logic [IDX_W-1:0]            right_r;

  assign vext  = {{(NCH*CHUNK_W){1'b0}}, vec};
  assign vpad  = vext[NCH*CHUNK_W-1:0];
  assign chunk = vpad[cnt_r*CHUNK_W +: CHUNK_W];

  always_comb begin
    lo = '0;
    hi = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (chunk[i]) lo = CHUNK_IW'(i);
    end
    for (int i = 0; i < CHUNK_W; i++) begin
      if (chunk[i]) hi = CHUNK_IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      found_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_CH);
      if (start) begin
        busy_r  <= 1'b1;
        found_r <= 1'b0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        if (chunk != '0) found_r <= 1'b1;
        if (cnt_r == LAST_CH) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      left_r  <= '0;
      right_r <= IDX_W'(SIZE - 1);
    end else if (busy_r && (chunk != '0)) begin
      if (!found_r) left_r <= IDX_W'({cnt_r, lo});
      right_r <= IDX_W'({cnt_r, hi});
    end
  end

  assign done  = done_r;
  assign left  = left_r;
  assign right = right_r;

  `BIBC_CHK_IMM(a_box_order, done_r, left_r <= right_r)
  `BIBC_CHK_IMM(a_cnt_in_range, busy_r, cnt_r <= LAST_CH)
  `BIBC_CHK_NXT(a_done_pulse, done_r, !done_r)

endmodule

### sv/binary_image_bbox_centering.sv
// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+------------------------------
// in       | in_valid, in_stall, in_row_pixels       | one image row per request
// out      | out_valid, out_stall, out_centered_row, | one centered row per request,
//          | out_last_row                            | SIZE of them per image
//
// Rows load one per cycle into the row RAM while in_stall is low. After the last
// row, the column scan walks the column union in 8-column chunks, the offset step
// computes the shifts, and then SIZE rows stream out at one per cycle through the
// RAM read port unless out_stall holds them.
// in_stall is high from the last row of an image until the last RAM read of its
// output is issued. out_stall pauses the read pipeline and holds the offset step
// until the previous image has left it. rst_n is synchronous; the RAM is not cleared.
`include "binary_image_bbox_centering_assert.svh"

module binary_image_bbox_centering #(
  parameter int SIZE = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bibc_pkg::ROW_W-1:0] in_row_pixels,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bibc_pkg::ROW_W-1:0] out_centered_row,
  output logic                       out_last_row
);
  import bibc_pkg::*;

  localparam int IDX_W = $clog2(SIZE);
  localparam int OFF_W = IDX_W + 2;
  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(SIZE - 1);
  localparam logic signed [OFF_W-1:0] HALF     = OFF_W'(SIZE / 2);
  localparam logic signed [OFF_W-1:0] SIZE_S   = OFF_W'(SIZE);

  state_t                  state_r;
  state_t                  state_nxt;
  logic [SIZE+ROW_W-1:0]   in_ext;
  logic [SIZE-1:0]         in_row;
  logic                    in_acc;
  logic [IDX_W-1:0]        rows_r;
  logic [IDX_W-1:0]        first_r;
  logic [IDX_W-1:0]        last_r;
  logic [SIZE-1:0]         union_r;
  logic                    any_r;
  logic                    scan_done;
  logic [IDX_W-1:0]        left;
  logic [IDX_W-1:0]        right;
  logic [IDX_W:0]          sum_x;
  logic [IDX_W:0]          sum_y;
  logic signed [OFF_W-1:0] offx_r;
  logic signed [OFF_W-1:0] offy_r;
  logic                    pipe_empty;
  logic [IDX_W-1:0]        er_r;
  logic signed [OFF_W-1:0] src;
  logic                    src_ok;
  logic                    issue;
  logic                    out_load;
  logic                    p1_vld_r;
  logic                    p1_rng_r;
  logic                    p1_last_r;
  logic [SIZE-1:0]         rd_data;
  logic [OFF_W-1:0]        mag;
  logic [SIZE-1:0]         shv;
  logic [SIZE+ROW_W-1:0]   out_ext;
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic                    out_last_r;

  assign in_ext   = {{SIZE{1'b0}}, in_row_pixels};
  assign in_row   = in_ext[SIZE-1:0];
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  assign pipe_empty = !p1_vld_r && !out_valid_r;
  assign out_load   = p1_vld_r && (!out_valid_r || !out_stall);
  assign issue      = (state_r == ST_EMIT) && (!p1_vld_r || out_load);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_acc && (rows_r == LAST_IDX)) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done) state_nxt = ST_OFFS;
      ST_OFFS: if (pipe_empty) state_nxt = ST_EMIT;
      ST_EMIT: if (issue && (er_r == LAST_IDX)) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      rows_r  <= '0;
      first_r <= '0;
      last_r  <= LAST_IDX;
      union_r <= '0;
      any_r   <= 1'b0;
      er_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        rows_r  <= (rows_r == LAST_IDX) ? '0 : rows_r + 1'b1;
        union_r <= union_r | in_row;
        if (in_row != '0) begin
          if (!any_r) first_r <= rows_r;
          last_r <= rows_r;
          any_r  <= 1'b1;
        end
      end
      if ((state_r == ST_OFFS) && pipe_empty) begin
        first_r <= '0;
        last_r  <= LAST_IDX;
        union_r <= '0;
        any_r   <= 1'b0;
        er_r    <= '0;
      end else if (issue) begin
        er_r <= er_r + 1'b1;
      end
    end
  end

  bibc_edge_scan #(
    .SIZE  (SIZE),
    .IDX_W (IDX_W)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (rows_r == LAST_IDX)),
    .vec   (union_r),
    .done  (scan_done),
    .left  (left),
    .right (right)
  );

  assign sum_x = {1'b0, left} + {1'b0, right};
  assign sum_y = {1'b0, first_r} + {1'b0, last_r};

  always_ff @(posedge clk) begin
    if ((state_r == ST_OFFS) && pipe_empty) begin
      offx_r <= HALF - $signed({2'b00, sum_x[IDX_W:1]});
      offy_r <= HALF - $signed({2'b00, sum_y[IDX_W:1]});
    end
  end

  assign src    = $signed({2'b00, er_r}) - offy_r;
  assign src_ok = !src[OFF_W-1] && (src < SIZE_S);

  bibc_row_ram #(
    .DEPTH (SIZE),
    .WIDTH (SIZE),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (rows_r),
    .wr_data (in_row),
    .rd_en   (issue && src_ok),
    .rd_addr (src[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (issue) begin
      p1_vld_r <= 1'b1;
    end else if (out_load) begin
      p1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_rng_r  <= src_ok;
      p1_last_r <= (er_r == LAST_IDX);
    end
  end

  assign mag     = offx_r[OFF_W-1] ? OFF_W'(-offx_r) : OFF_W'(offx_r);
  assign shv     = offx_r[OFF_W-1] ? (rd_data >> mag) : (rd_data << mag);
  assign out_ext = {{ROW_W{1'b0}}, shv};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= p1_rng_r ? out_ext[ROW_W-1:0] : '0;
      out_last_r <= p1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_centered_row = out_row_r;
  assign out_last_row     = out_last_r;

  `BIBC_CHK_IMM(a_rows_clear_in_emit, state_r == ST_EMIT, rows_r == '0)
  `BIBC_CHK_NXT(a_last_row_to_scan, in_acc && (rows_r == LAST_IDX), state_r == ST_SCAN)
  `BIBC_CHK_NXT(a_p1_hold_on_stall, p1_vld_r && out_valid_r && out_stall, p1_vld_r)

endmodule

### test/tb_binary_image_bbox_centering.sv
`timescale 1ns / 100ps

module tb_binary_image_bbox_centering;
  import bibc_pkg::ROW_W;

  localparam int SIZE = 40;
  localparam int DRAIN_CYCLES = 2 * SIZE + SIZE / 8 + 20;
  localparam logic [ROW_W-1:0] FRAME_MASK = {ROW_W{1'b1}} >> (ROW_W - SIZE);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } centered_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [ROW_W-1:0] in_row_pixels;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ROW_W-1:0] out_centered_row;
  logic             out_last_row;

  centered_row_t    expected_rows[$];
  int               mismatch_count;
  int               sender_idle_pct;
  int               receiver_stall_pct;

  logic [ROW_W-1:0] image_rows[SIZE];
  int               rows_taken;
  int               first_marked;
  int               last_marked;
  logic [ROW_W-1:0] column_union;
  bit               any_marked;

  binary_image_bbox_centering #(
    .SIZE(SIZE)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_row_pixels   (in_row_pixels),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_centered_row(out_centered_row),
    .out_last_row    (out_last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < receiver_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                 input logic [ROW_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count = mismatch_count + 1;
  endtask

  always @(posedge clk) begin
    centered_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row", out_centered_row, '0);
      end else begin
        want = expected_rows.pop_front();
        if (out_centered_row !== want.row)
          report_mismatch("centered_row", out_centered_row, want.row);
        if (out_last_row !== want.last)
          report_mismatch("last_row", ROW_W'(out_last_row), ROW_W'(want.last));
      end
    end
  end

  task automatic clear_image_state();
    rows_taken   = 0;
    first_marked = 0;
    last_marked  = SIZE - 1;
    column_union = '0;
    any_marked   = 1'b0;
  endtask

  // Store the row; on the last row of an image, queue the recentered image.
  task automatic predict_centering(input logic [ROW_W-1:0] row_in);
    logic [ROW_W-1:0] masked;
    logic [ROW_W-1:0] shifted;
    int               top;
    int               bottom;
    int               left;
    int               right;
    int               dx;
    int               dy;
    int               src;
    masked = row_in & FRAME_MASK;
    image_rows[rows_taken] = masked;
    if (masked != '0) begin
      if (!any_marked) first_marked = rows_taken;
      last_marked = rows_taken;
      any_marked  = 1'b1;
    end
    column_union = column_union | masked;
    if (rows_taken + 1 < SIZE) begin
      rows_taken = rows_taken + 1;
      return;
    end
    top    = 0;
    bottom = SIZE - 1;
    left   = 0;
    right  = SIZE - 1;
    if (any_marked) begin
      top    = first_marked;
      bottom = last_marked;
      for (int i = SIZE - 1; i >= 0; i--) if (column_union[i]) left = i;
      for (int i = 0; i < SIZE; i++) if (column_union[i]) right = i;
    end
    dx = SIZE / 2 - (left + right) / 2;
    dy = SIZE / 2 - (top + bottom) / 2;
    for (int r = 0; r < SIZE; r++) begin
      src = r - dy;
      shifted = '0;
      if (src >= 0 && src < SIZE) begin
        if (dx >= 0) shifted = (image_rows[src] << dx) & FRAME_MASK;
        else shifted = image_rows[src] >> (-dx);
      end
      expected_rows.push_back('{row: shifted, last: (r == SIZE - 1)});
    end
    clear_image_state();
  endtask

  task automatic send_row(input logic [ROW_W-1:0] row);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid      = 1'b0;
      in_row_pixels = ROW_W'({$urandom, $urandom});
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_row_pixels = row;
    do @(posedge clk); while (in_stall);
    predict_centering(row);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  // Box with random content, sparse dots, dense noise, or scattered full-width and box-width rows.
  task automatic send_random_image();
    int               shape;
    int               top;
    int               bottom;
    int               left;
    int               right;
    logic [ROW_W-1:0] box_cols;
    logic [ROW_W-1:0] row;
    shape  = $urandom_range(0, 4);
    top    = $urandom_range(0, SIZE - 1);
    bottom = $urandom_range(top, SIZE - 1);
    left   = $urandom_range(0, SIZE - 1);
    right  = $urandom_range(left, SIZE - 1);
    box_cols = '0;
    for (int c = left; c <= right; c++) box_cols[c] = 1'b1;
    for (int r = 0; r < SIZE; r++) begin
      row = ROW_W'({$urandom, $urandom});
      case (shape)
        0, 1: begin
          row = (r >= top && r <= bottom) ? (row & box_cols) : '0;
        end
        2: begin
          row = ($urandom_range(0, 7) == 0) ? (ROW_W'(1) << $urandom_range(0, SIZE - 1)) : '0;
        end
        3: begin
          row = row;
        end
        default: begin
          row = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? '1 : box_cols) : '0;
        end
      endcase
      send_row(row);
    end
  endtask

  task automatic test_empty_image();
    for (int r = 0; r < SIZE; r++) send_row('0);
  endtask

  task automatic test_single_pixel_top_left();
    for (int r = 0; r < SIZE; r++) send_row((r == 0) ? ROW_W'(1) : '0);
  endtask

  task automatic test_single_pixel_bottom_right();
    for (int r = 0; r < SIZE; r++) send_row((r == SIZE - 1) ? (ROW_W'(1) << (SIZE - 1)) : '0);
  endtask

  task automatic test_random_images(input int idle_pct, input int stall_pct, input int images);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < images; n++) send_random_image();
  endtask

  task automatic test_paused_sender();
    sender_idle_pct    = 34;
    receiver_stall_pct = 34;
    wait_for_drain();
    send_random_image();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_row_pixels      = '0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    clear_image_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_image();
    test_single_pixel_top_left();
    test_single_pixel_bottom_right();
    test_random_images(0, 0, 1);
    test_random_images(61, 0, 1);
    test_random_images(0, 61, 1);
    test_paused_sender();

    wait_for_drain();
    receiver_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("binary_image_bbox_centering regression: pass");
    end else begin
      $display("binary_image_bbox_centering regression: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("binary_image_bbox_centering regression: fail");
    $finish;
  end

endmodule
